### hw/rtl/frame_376_2_checker_parser_assert.svh
// Assertion macros shared by the frame checker RTL.
`ifndef FRAME_376_2_CHECKER_PARSER_ASSERT_SVH
`define FRAME_376_2_CHECKER_PARSER_ASSERT_SVH

// Hold cons in the same cycle as ante.
`define FCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Hold cons in the cycle after ante.
`define FCP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/fcp_pkg.sv
`default_nettype none

package fcp_pkg;

  typedef enum logic [3:0] {
    KindStart   = 4'd0,
    KindLength  = 4'd1,
    KindControl = 4'd2,
    KindInfo    = 4'd3,
    KindSrc     = 4'd4,
    KindDst     = 4'd5,
    KindAfn     = 4'd6,
    KindFn      = 4'd7,
    KindData    = 4'd8,
    KindCs      = 4'd9,
    KindEnd     = 4'd10,
    KindOutside = 4'd11
  } kind_e;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusBadStart  = 3'd1,
    StatusBadLength = 3'd2,
    StatusBadEnd    = 3'd3,
    StatusBadCsum   = 3'd4,
    StatusTruncated = 3'd5
  } status_e;

  localparam logic [7:0]  StartByte    = 8'h68;
  localparam logic [7:0]  EndByte      = 8'h16;
  localparam logic [15:0] MinLength    = 16'd12;
  localparam int unsigned DirBit       = 7;
  localparam int unsigned AddrBit      = 2;
  localparam logic [7:0]  MeterAfn     = 8'h14;
  localparam logic [15:0] MeterFn      = 16'h0100;
  localparam logic [15:0] IdxLenHigh   = 16'd2;
  localparam logic [15:0] IdxLenLow    = 16'd1;
  localparam logic [15:0] IdxControl   = 16'd3;
  localparam logic [15:0] IdxInfo0     = 16'd4;
  localparam logic [15:0] IdxInfoLast  = 16'd9;
  localparam logic [15:0] IdxSrcLast   = 16'd15;
  localparam logic [15:0] IdxDstLast   = 16'd21;
  localparam logic [15:0] AfnNoAddr    = 16'd10;
  localparam logic [15:0] AfnWithAddr  = 16'd22;
  localparam logic [15:0] MeterLenLast = 16'd6;

  typedef struct packed {
    logic [7:0]  byte_out;
    kind_e       field_kind;
    logic [15:0] field_pos;
    logic        meter_addr;
    logic        direction_up;
    logic        frame_done;
    status_e     frame_status;
    logic        aborted_previous;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/frame_376_2_checker_parser.sv
// Channel  Dir  tdata (low bit up)                              tuser          tlast
// s_axis   in   rx_byte                                         first          -
// m_axis   out  byte_out, field_pos, meter_addr, direction_up,  field_kind     frame_done
//               frame_status, aborted_previous, zero pad
//
// One byte per cycle while the queue has room; each byte is tagged in the cycle
// it is taken and its result is registered in the result queue, which feeds m_axis.
// The front holds all frame state; index compares set the path, the running sum the verdict.
// Reset clears frame state and empties the queue; no clearing pass.
// A stalled m_axis fills the queue of QueueDepth results, then s_axis_tready drops.
`default_nettype none

module frame_376_2_checker_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  input  wire logic [0:0]  s_axis_tuser,   // first
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // byte_out, field_pos, meter_addr,
                                           // direction_up, frame_status, aborted_previous
  output logic [3:0]       m_axis_tuser,   // field_kind
  output logic             m_axis_tlast    // frame_done
);

  fcp_pkg::result_t front_res;
  fcp_pkg::result_t head;
  logic             full;
  logic             accept;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  fcp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (s_axis_tdata),
    .first_i   (s_axis_tuser[0]),
    .accept_i  (accept),
    .res_o     (front_res)
  );

  fcp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_res),
    .full_o      (full),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (head)
  );

  assign m_axis_tdata = {2'b00, head.aborted_previous, head.frame_status,
                         head.direction_up, head.meter_addr, head.field_pos,
                         head.byte_out};
  assign m_axis_tuser = head.field_kind;
  assign m_axis_tlast = head.frame_done;

endmodule

`default_nettype wire

### hw/rtl/fcp_front.sv
`default_nettype none

module fcp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            first_i,
  input  wire logic            accept_i,
  output fcp_pkg::result_t     res_o
);

  logic        in_frame_q, in_frame_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  len_low_q, len_low_d;
  logic [7:0]  sum_q, sum_d;
  logic        addr_q, addr_d;
  logic        up_q, up_d;
  logic [7:0]  afn_q, afn_d;
  logic [15:0] fn_q, fn_d;

  fcp_pkg::result_t res;

  always_comb begin
    logic [15:0] full_len;
    logic [15:0] afn_idx;
    logic [15:0] p;
    full_len  = {rx_byte_i, len_low_q};
    afn_idx   = addr_q ? fcp_pkg::AfnWithAddr : fcp_pkg::AfnNoAddr;
    p         = idx_q - (afn_idx + 16'd3);

    in_frame_d = in_frame_q;
    idx_d      = idx_q;
    len_d      = len_q;
    len_low_d  = len_low_q;
    sum_d      = sum_q;
    addr_d     = addr_q;
    up_d       = up_q;
    afn_d      = afn_q;
    fn_d       = fn_q;

    res.byte_out         = rx_byte_i;
    res.field_kind       = fcp_pkg::KindOutside;
    res.field_pos        = '0;
    res.meter_addr       = 1'b0;
    res.direction_up     = 1'b0;
    res.frame_done       = 1'b0;
    res.frame_status     = fcp_pkg::StatusOk;
    res.aborted_previous = 1'b0;

    if (first_i) begin
      res.aborted_previous = in_frame_q;
      res.field_kind       = fcp_pkg::KindStart;
      in_frame_d           = 1'b0;
      idx_d                = '0;
      if (rx_byte_i != fcp_pkg::StartByte) begin
        res.frame_done   = 1'b1;
        res.frame_status = fcp_pkg::StatusBadStart;
      end else begin
        if (in_frame_q) begin
          res.frame_done   = 1'b1;
          res.frame_status = fcp_pkg::StatusTruncated;
        end
        in_frame_d = 1'b1;
        idx_d      = 16'd1;
        len_d      = '0;
        len_low_d  = '0;
        sum_d      = '0;
        addr_d     = 1'b0;
        up_d       = 1'b0;
        afn_d      = '0;
        fn_d       = '0;
      end
    end else if (in_frame_q) begin
      if (idx_q == fcp_pkg::IdxLenLow) begin
        res.field_kind = fcp_pkg::KindLength;
        len_low_d      = rx_byte_i;
        idx_d          = idx_q + 16'd1;
      end else if (idx_q == fcp_pkg::IdxLenHigh) begin
        res.field_kind = fcp_pkg::KindLength;
        res.field_pos  = 16'd1;
        len_d          = full_len;
        if (full_len < fcp_pkg::MinLength) begin
          res.frame_done   = 1'b1;
          res.frame_status = fcp_pkg::StatusBadLength;
          in_frame_d       = 1'b0;
        end else begin
          idx_d = idx_q + 16'd1;
        end
      end else begin
        res.direction_up = up_q;
        if (idx_q == len_q - 16'd1) begin
          res.field_kind = fcp_pkg::KindEnd;
          res.frame_done = 1'b1;
          in_frame_d     = 1'b0;
          if (rx_byte_i != fcp_pkg::EndByte) begin
            res.frame_status = fcp_pkg::StatusBadEnd;
          end else if (sum_q != 8'd0) begin
            res.frame_status = fcp_pkg::StatusBadCsum;
          end
        end else if (idx_q == len_q - 16'd2) begin
          res.field_kind = fcp_pkg::KindCs;
          sum_d          = sum_q - rx_byte_i;
          idx_d          = idx_q + 16'd1;
        end else begin
          sum_d = sum_q + rx_byte_i;
          idx_d = idx_q + 16'd1;
          if (idx_q == fcp_pkg::IdxControl) begin
            res.field_kind   = fcp_pkg::KindControl;
            up_d             = rx_byte_i[fcp_pkg::DirBit];
            res.direction_up = rx_byte_i[fcp_pkg::DirBit];
          end else if (idx_q <= fcp_pkg::IdxInfoLast) begin
            res.field_kind = fcp_pkg::KindInfo;
            res.field_pos  = idx_q - fcp_pkg::IdxInfo0;
            if (idx_q == fcp_pkg::IdxInfo0) begin
              addr_d = rx_byte_i[fcp_pkg::AddrBit];
            end
          end else if (addr_q && idx_q <= fcp_pkg::IdxSrcLast) begin
            res.field_kind = fcp_pkg::KindSrc;
            res.field_pos  = fcp_pkg::IdxSrcLast - idx_q;
          end else if (addr_q && idx_q <= fcp_pkg::IdxDstLast) begin
            res.field_kind = fcp_pkg::KindDst;
            res.field_pos  = fcp_pkg::IdxDstLast - idx_q;
          end else if (idx_q == afn_idx) begin
            res.field_kind = fcp_pkg::KindAfn;
            afn_d          = rx_byte_i;
          end else if (idx_q == afn_idx + 16'd1) begin
            res.field_kind = fcp_pkg::KindFn;
            fn_d           = {rx_byte_i, fn_q[7:0]};
          end else if (idx_q == afn_idx + 16'd2) begin
            res.field_kind = fcp_pkg::KindFn;
            res.field_pos  = 16'd1;
            fn_d           = {fn_q[15:8], rx_byte_i};
          end else begin
            res.field_kind = fcp_pkg::KindData;
            res.field_pos  = p;
            if (up_q && afn_q == fcp_pkg::MeterAfn && fn_q == fcp_pkg::MeterFn &&
                p >= 16'd1 && p <= fcp_pkg::MeterLenLast) begin
              res.meter_addr = 1'b1;
              res.field_pos  = fcp_pkg::MeterLenLast - p;
            end
          end
        end
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      len_q      <= '0;
      len_low_q  <= '0;
      sum_q      <= '0;
      addr_q     <= 1'b0;
      up_q       <= 1'b0;
      afn_q      <= '0;
      fn_q       <= '0;
    end else if (accept_i) begin
      in_frame_q <= in_frame_d;
      idx_q      <= idx_d;
      len_q      <= len_d;
      len_low_q  <= len_low_d;
      sum_q      <= sum_d;
      addr_q     <= addr_d;
      up_q       <= up_d;
      afn_q      <= afn_d;
      fn_q       <= fn_d;
    end
  end

`include "frame_376_2_checker_parser_assert.svh"

  `FCP_ASSERT_IMP(a_status_has_verdict, clk_i, rst_ni, res.frame_status != fcp_pkg::StatusOk, res.frame_done)
  `FCP_ASSERT_IMP(a_meter_is_up_data, clk_i, rst_ni, res.meter_addr, res.field_kind == fcp_pkg::KindData && up_q)
  `FCP_ASSERT_IMP(a_open_length_sane, clk_i, rst_ni, in_frame_q && idx_q > fcp_pkg::IdxLenHigh, len_q >= fcp_pkg::MinLength && idx_q < len_q)
  `FCP_ASSERT_NXT(a_bad_start_closes, clk_i, rst_ni, accept_i && first_i && rx_byte_i != fcp_pkg::StartByte, !in_frame_q)

endmodule

`default_nettype wire

### hw/rtl/fcp_fifo.sv
`default_nettype none

module fcp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire fcp_pkg::result_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output fcp_pkg::result_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  fcp_pkg::result_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire
